// ===== src/vrrl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrrl_pkg
// Shared types, codes and helpers for the variable record ring log.
// ----------------------------------------------------------------------------
package vrrl_pkg;

	localparam int unsigned CAPACITY_DEF     = 4096;
	localparam int unsigned HEADER_BYTES_DEF = 32;

	typedef enum logic [2:0] {
		OP_PUSH    = 3'd0,
		OP_PAYLOAD = 3'd1,
		OP_POP     = 3'd2,
		OP_RHDR    = 3'd3,
		OP_RBYTE   = 3'd4
	} op_t;

	typedef struct packed {
		logic [11:0] len;
		logic [15:0] kind;
		logic [31:0] id;
		logic [63:0] secs;
		logic [29:0] nsecs;
	} hdr_t;

	typedef struct packed {
		logic load_item;
		logic set_ok;
		logic do_pop;
		logic do_hbyte;
		logic do_place;
		logic do_wbyte;
		logic do_rbyte;
		logic load_data;
		logic load_front;
		logic load_out;
	} vrrl_cmd_t;

	typedef struct packed {
		logic [2:0] op;
		logic       too_large;
		logic       need_evict;
		logic       hdr_last;
		logic       has_payload;
		logic       empty;
		logic       ofs_ok;
	} vrrl_sts_t;

	// zero the bytes of a header field that lie at or beyond the header size
	function automatic logic [63:0] hdr_keep(logic [63:0] v, int unsigned off,
			int unsigned hb);
		logic [63:0] r;
		r = v;
		for (int unsigned i = 0; i < 8; i++) begin
			if (off + i >= hb)
				r[i*8 +: 8] = 8'd0;
		end
		return r;
	endfunction

endpackage

// ===== src/vrrl_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrrl_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module vrrl_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end

endmodule

// ===== src/vrrl_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrrl_ctrl
// Sequencer for the record ring: decode, eviction loop, front refresh, result.
// ----------------------------------------------------------------------------
module vrrl_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	output logic                out_valid,
	input  logic                out_stall,
	input  vrrl_pkg::vrrl_sts_t sts,
	output vrrl_pkg::vrrl_cmd_t cmd
);
	import vrrl_pkg::*;

	typedef enum logic [7:0] {
		S_IDLE   = 8'b00000001,
		S_DECODE = 8'b00000010,
		S_EVICT  = 8'b00000100,
		S_HDR    = 8'b00001000,
		S_WAIT   = 8'b00010000,
		S_FRONT  = 8'b00100000,
		S_RWAIT  = 8'b01000000,
		S_FINISH = 8'b10000000
	} state_t;

	state_t state_q, state_d;
	logic   ret_q, ret_d;
	logic   oval_q;
	logic   out_free;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = oval_q;
	assign out_free  = !oval_q || !out_stall;

	always_comb begin
		state_d = state_q;
		ret_d   = ret_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_item = 1'b1;
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				state_d = S_FINISH;
				case (op_t'(sts.op))
					OP_PUSH: begin
						if (!sts.too_large)
							state_d = S_EVICT;
					end
					OP_PAYLOAD: begin
						if (sts.has_payload) begin
							cmd.do_wbyte = 1'b1;
							cmd.set_ok = 1'b1;
						end
					end
					OP_POP: begin
						if (!sts.empty) begin
							cmd.do_pop = 1'b1;
							cmd.set_ok = 1'b1;
							ret_d = 1'b0;
							state_d = S_WAIT;
						end
					end
					OP_RHDR: begin
						cmd.set_ok = !sts.empty;
					end
					OP_RBYTE: begin
						if (!sts.empty && sts.ofs_ok) begin
							cmd.do_rbyte = 1'b1;
							cmd.set_ok = 1'b1;
							state_d = S_RWAIT;
						end
					end
					default: state_d = S_FINISH;
				endcase
			end
			S_EVICT: begin
				if (sts.need_evict) begin
					cmd.do_pop = 1'b1;
					ret_d = 1'b1;
					state_d = S_WAIT;
				end else begin
					state_d = S_HDR;
				end
			end
			S_HDR: begin
				cmd.do_hbyte = 1'b1;
				if (sts.hdr_last) begin
					cmd.do_place = 1'b1;
					cmd.set_ok = 1'b1;
					state_d = S_FINISH;
				end
			end
			S_WAIT: state_d = S_FRONT;
			S_FRONT: begin
				cmd.load_front = 1'b1;
				state_d = ret_q ? S_EVICT : S_FINISH;
			end
			S_RWAIT: begin
				cmd.load_data = 1'b1;
				state_d = S_FINISH;
			end
			S_FINISH: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ret_q   <= 1'b0;
			oval_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
			if (cmd.load_out)
				oval_q <= 1'b1;
			else if (!out_stall)
				oval_q <= 1'b0;
		end
	end

endmodule

// ===== src/vrrl_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrrl_dp
// Ring pointers, header queue, byte store and result registers.
// ----------------------------------------------------------------------------
module vrrl_dp #(
	parameter int unsigned CAPACITY     = vrrl_pkg::CAPACITY_DEF,
	parameter int unsigned HEADER_BYTES = vrrl_pkg::HEADER_BYTES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  vrrl_pkg::vrrl_cmd_t cmd,
	output vrrl_pkg::vrrl_sts_t sts,
	input  logic [2:0]          op,
	input  logic [11:0]         rec_len,
	input  logic [15:0]         rec_kind,
	input  logic [31:0]         rec_id,
	input  logic                auto_id,
	input  logic [63:0]         ts_secs,
	input  logic [29:0]         ts_nsecs,
	input  logic [7:0]          data_byte,
	input  logic [11:0]         byte_offset,
	output logic                ok,
	output logic [11:0]         position,
	output logic [7:0]          evicted,
	output logic [11:0]         space_left,
	output logic [7:0]          record_count,
	output logic [11:0]         front_len,
	output logic [15:0]         front_kind,
	output logic [31:0]         front_id,
	output logic [63:0]         front_secs,
	output logic [29:0]         front_nsecs,
	output logic [7:0]          data_out
);
	import vrrl_pkg::*;

	localparam int unsigned AW     = $clog2(CAPACITY);
	localparam int unsigned SW     = ((AW > 12) ? AW : 12) + 2;
	localparam int unsigned HDEPTH = CAPACITY / HEADER_BYTES + 1;
	localparam int unsigned IW     = $clog2(HDEPTH);
	localparam int unsigned CW     = $clog2(HDEPTH + 1);
	localparam int unsigned HSTORE = (HEADER_BYTES < 20) ? HEADER_BYTES : 20;
	localparam int unsigned HCW    = $clog2(HSTORE);
	localparam logic [SW-1:0] CAP_S = SW'(CAPACITY);
	localparam logic [SW-1:0] HB_S  = SW'(HEADER_BYTES);

	logic [2:0]  op_q;
	logic [11:0] len_q, ofs_q;
	logic [15:0] kind_q;
	logic [31:0] rid_q;
	logic        auto_q;
	logic [63:0] secs_q;
	logic [29:0] ns_q;
	logic [7:0]  byte_q;

	logic [AW-1:0]  start_q, end_q, skip_q, pptr_q;
	logic [CW-1:0]  cnt_q;
	logic [31:0]    idc_q;
	logic [11:0]    pleft_q;
	logic [IW-1:0]  head_q, tail_q;
	logic [HCW-1:0] hbc_q;
	hdr_t           front_q;
	logic           ok_q;
	logic [AW-1:0]  posn_q;
	logic [7:0]     evict_q;
	logic [7:0]     data_q;

	logic [SW-1:0] tot, space, a_room, b_room, pop_next, end_sum, pptr_next;
	logic          fit;
	logic [AW-1:0] place_pos, place_end;
	logic [31:0]   id_sel;
	hdr_t          new_hdr, hq_rdata;
	logic [7:0]    bs_rdata;
	logic [AW-1:0] rd_addr;
	logic [159:0]  hbytes;
	logic [7:0]    hbyte;
	logic [AW-1:0] haddr, bs_waddr;
	logic [7:0]    bs_wdata;
	logic          bs_we;

	assign tot = SW'(len_q) + HB_S;

	always_comb begin
		a_room = CAP_S - (SW'(end_q) + SW'(1));
		b_room = (start_q == '0) ? '0 : SW'(start_q) - SW'(1);
		if (cnt_q == '0)
			space = CAP_S - SW'(1);
		else if (start_q < end_q)
			space = (a_room > b_room) ? a_room : b_room;
		else if (start_q > end_q)
			space = SW'(start_q) - SW'(end_q) - SW'(1);
		else
			space = '0;
	end

	assign pop_next  = SW'(start_q) + SW'(front_q.len) + HB_S;
	assign end_sum   = SW'(end_q) + tot;
	assign fit       = (end_sum <= CAP_S);
	assign place_pos = fit ? end_q : '0;
	assign place_end = fit ? ((end_sum == CAP_S) ? '0 : AW'(end_sum)) : AW'(tot);
	assign pptr_next = SW'(place_pos) + HB_S;
	assign id_sel    = auto_q ? idc_q : rid_q;

	always_comb begin
		new_hdr.len   = 12'(hdr_keep(64'(len_q), 0, HEADER_BYTES));
		new_hdr.kind  = 16'(hdr_keep(64'(kind_q), 2, HEADER_BYTES));
		new_hdr.id    = 32'(hdr_keep(64'(id_sel), 4, HEADER_BYTES));
		new_hdr.secs  = hdr_keep(secs_q, 8, HEADER_BYTES);
		new_hdr.nsecs = 30'(hdr_keep(64'(ns_q), 16, HEADER_BYTES));
	end

	assign hbytes   = {2'b00, ns_q, secs_q, id_sel, kind_q, 4'h0, len_q};
	assign hbyte    = hbytes[8*hbc_q +: 8];
	assign haddr    = AW'(SW'(place_pos) + SW'(hbc_q));
	assign bs_we    = cmd.do_wbyte | cmd.do_hbyte;
	assign bs_waddr = cmd.do_hbyte ? haddr : pptr_q;
	assign bs_wdata = cmd.do_hbyte ? hbyte : byte_q;

	assign rd_addr = AW'(SW'(start_q) + HB_S + SW'(ofs_q));

	assign sts.op          = op_q;
	assign sts.too_large   = (tot + SW'(1)) > CAP_S;
	assign sts.need_evict  = (cnt_q != '0) && (tot > space);
	assign sts.hdr_last    = (hbc_q == HCW'(HSTORE - 1));
	assign sts.has_payload = (pleft_q != '0);
	assign sts.empty       = (cnt_q == '0);
	assign sts.ofs_ok      = (ofs_q < front_q.len);

	vrrl_ram #(.WIDTH($bits(hdr_t)), .DEPTH(HDEPTH)) u_hdr_ram (
		.clk   (clk),
		.we    (cmd.do_place),
		.waddr (tail_q),
		.wdata (new_hdr),
		.raddr (head_q),
		.rdata (hq_rdata)
	);

	vrrl_ram #(.WIDTH(8), .DEPTH(CAPACITY)) u_byte_ram (
		.clk   (clk),
		.we    (bs_we),
		.waddr (bs_waddr),
		.wdata (bs_wdata),
		.raddr (rd_addr),
		.rdata (bs_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			op_q   <= op;
			len_q  <= rec_len;
			kind_q <= rec_kind;
			rid_q  <= rec_id;
			auto_q <= auto_id;
			secs_q <= ts_secs;
			ns_q   <= ts_nsecs;
			byte_q <= data_byte;
			ofs_q  <= byte_offset;
		end
		if (cmd.load_out) begin
			position     <= 12'(posn_q);
			evicted      <= evict_q;
			space_left   <= 12'(space);
			record_count <= 8'(cnt_q);
			data_out     <= data_q;
			front_len    <= sts.empty ? '0 : front_q.len;
			front_kind   <= sts.empty ? '0 : front_q.kind;
			front_id     <= sts.empty ? '0 : front_q.id;
			front_secs   <= sts.empty ? '0 : front_q.secs;
			front_nsecs  <= sts.empty ? '0 : front_q.nsecs;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
			end_q   <= '0;
			skip_q  <= '0;
			pptr_q  <= '0;
			cnt_q   <= '0;
			idc_q   <= '0;
			pleft_q <= '0;
			head_q  <= '0;
			tail_q  <= '0;
			hbc_q   <= '0;
			front_q <= '0;
			ok_q    <= 1'b0;
			posn_q  <= '0;
			evict_q <= '0;
			data_q  <= '0;
			ok      <= 1'b0;
		end else begin
			if (cmd.load_item) begin
				ok_q    <= 1'b0;
				posn_q  <= '0;
				evict_q <= '0;
				data_q  <= '0;
				hbc_q   <= '0;
			end
			if (cmd.do_hbyte)
				hbc_q <= hbc_q + HCW'(1);
			if (cmd.set_ok)
				ok_q <= 1'b1;
			if (cmd.load_out)
				ok <= ok_q;
			if (cmd.load_data)
				data_q <= bs_rdata;
			if (cmd.load_front)
				front_q <= hq_rdata;
			if (cmd.do_wbyte) begin
				pptr_q  <= (SW'(pptr_q) + SW'(1) == CAP_S) ? '0 : pptr_q + AW'(1);
				pleft_q <= pleft_q - 12'd1;
			end
			if (cmd.do_pop) begin
				evict_q <= evict_q + 8'(op_q == OP_PUSH);
				cnt_q   <= cnt_q - CW'(1);
				head_q  <= (head_q == IW'(HDEPTH - 1)) ? '0 : head_q + IW'(1);
				if (cnt_q == CW'(1)) begin
					start_q <= '0;
					end_q   <= '0;
					skip_q  <= '0;
					pleft_q <= '0;
				end else if (skip_q != '0 && pop_next == SW'(skip_q)) begin
					start_q <= '0;
					skip_q  <= '0;
				end else if (pop_next >= CAP_S) begin
					start_q <= '0;
				end else begin
					start_q <= AW'(pop_next);
				end
			end
			if (cmd.do_place) begin
				if (!fit)
					skip_q <= end_q;
				end_q   <= place_end;
				posn_q  <= place_pos;
				cnt_q   <= cnt_q + CW'(1);
				tail_q  <= (tail_q == IW'(HDEPTH - 1)) ? '0 : tail_q + IW'(1);
				pptr_q  <= (pptr_next == CAP_S) ? '0 : AW'(pptr_next);
				pleft_q <= len_q;
				if (auto_q)
					idc_q <= idc_q + 32'd1;
				if (cnt_q == '0)
					front_q <= new_hdr;
			end
		end
	end

endmodule

// ===== src/variable_record_ring_log.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// variable_record_ring_log
// Byte ring of variable-length log records with eviction on push.
// ----------------------------------------------------------------------------
//  channel | handshake           | payload
//  in      | in_valid / in_stall | op, rec_len, rec_kind, rec_id, auto_id,
//          |                     | ts_secs, ts_nsecs, data_byte, byte_offset
//  out     | out_valid/out_stall | ok, position, evicted, space_left, record_count,
//          |                     | front_len..front_nsecs, data_out
//
// One transaction at a time. A header read, payload byte, failed op or unknown op
// goes from decode to the result. A byte read adds a read wait; a pop adds a wait
// and a front refresh. A push evicts records, each eviction refreshing the front
// header via the queue's read port, then writes the header bytes to the byte store.
// Reset clears pointers and counts at once; the byte store is not cleared.
// The result waits in the output register while out_stall is high; a new
// transaction is taken meanwhile and then holds until the result is taken.
module variable_record_ring_log #(
	parameter int unsigned CAPACITY     = vrrl_pkg::CAPACITY_DEF,
	parameter int unsigned HEADER_BYTES = vrrl_pkg::HEADER_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  op,
	input  logic [11:0] rec_len,
	input  logic [15:0] rec_kind,
	input  logic [31:0] rec_id,
	input  logic        auto_id,
	input  logic [63:0] ts_secs,
	input  logic [29:0] ts_nsecs,
	input  logic [7:0]  data_byte,
	input  logic [11:0] byte_offset,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        ok,
	output logic [11:0] position,
	output logic [7:0]  evicted,
	output logic [11:0] space_left,
	output logic [7:0]  record_count,
	output logic [11:0] front_len,
	output logic [15:0] front_kind,
	output logic [31:0] front_id,
	output logic [63:0] front_secs,
	output logic [29:0] front_nsecs,
	output logic [7:0]  data_out
);
	import vrrl_pkg::*;

	vrrl_cmd_t cmd;
	vrrl_sts_t sts;

	vrrl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	vrrl_dp #(.CAPACITY(CAPACITY), .HEADER_BYTES(HEADER_BYTES)) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.op           (op),
		.rec_len      (rec_len),
		.rec_kind     (rec_kind),
		.rec_id       (rec_id),
		.auto_id      (auto_id),
		.ts_secs      (ts_secs),
		.ts_nsecs     (ts_nsecs),
		.data_byte    (data_byte),
		.byte_offset  (byte_offset),
		.ok           (ok),
		.position     (position),
		.evicted      (evicted),
		.space_left   (space_left),
		.record_count (record_count),
		.front_len    (front_len),
		.front_kind   (front_kind),
		.front_id     (front_id),
		.front_secs   (front_secs),
		.front_nsecs  (front_nsecs),
		.data_out     (data_out)
	);

endmodule
